// ===== src/tstp_pkg.sv =====
// Shared types, character codes and limits of the timestamp text parser.
package tstp_pkg;

	localparam int unsigned MAX_LENGTH_DEF = 256;

	typedef enum logic [8:0] {
		PH_YEAR     = 9'b000000001,
		PH_MONTH    = 9'b000000010,
		PH_DAY      = 9'b000000100,
		PH_HOUR     = 9'b000001000,
		PH_MINUTE   = 9'b000010000,
		PH_SECOND   = 9'b000100000,
		PH_FRACTION = 9'b001000000,
		PH_OFFSET   = 9'b010000000,
		PH_FAILED   = 9'b100000000
	} phase_t;

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_BADCHAR = 2'd1,
		ST_EARLY   = 2'd2
	} status_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	localparam logic [7:0] MONTH_MAX   = 8'd12;
	localparam logic [9:0] HOUR_MAX    = 10'd24;
	localparam logic [9:0] MIN_SEC_MAX = 10'd60;
	localparam logic [4:0] DAY_LONG    = 5'd31;
	localparam logic [4:0] DAY_SHORT   = 5'd30;
	localparam logic [4:0] DAY_FEB     = 5'd28;

	localparam logic [2:0] OFS_SHORT_LEN = 3'd4;
	localparam logic [2:0] OFS_LONG_LEN  = 3'd5;
	localparam logic [2:0] OFS_COUNT_MAX = 3'd6;
	localparam logic [2:0] OFS_SEP_IDX   = 3'd2;
	localparam logic [2:0] OFS_COLON_BIT = 3'd5;

	function automatic logic [4:0] day_limit(input logic [3:0] month, input logic [1:0] year_low);
		logic [4:0] lim;
		case (month) inside
			4'd4, 4'd6, 4'd9, 4'd11: lim = DAY_SHORT;
			4'd2: lim = DAY_FEB + {4'd0, (year_low == 2'd0)};
			default: lim = DAY_LONG;
		endcase
		return lim;
	endfunction

	function automatic logic [9:0] step10(input logic [9:0] acc, input logic has_digit,
		input logic [3:0] dig);
		logic [9:0] val;
		val = has_digit ? 10'(acc * 10'd10 + {6'd0, dig}) : {6'd0, dig};
		return val;
	endfunction

endpackage

// ===== src/tstp_if.sv =====
// Handshake channels for text characters and parsed timestamp results.
interface tstp_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source(output valid, output text_byte, output end_of_text, input ready);
	modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tstp_result_if;
	logic              valid;
	logic              ready;
	logic [15:0]       year_value;
	logic [3:0]        month_value;
	logic [4:0]        day_value;
	logic [4:0]        hour_value;
	logic [5:0]        minute_value;
	logic [5:0]        second_value;
	logic [31:0]       fraction_value;
	logic signed [7:0] offset_hours;
	logic signed [7:0] offset_minutes;
	logic [1:0]        parse_status;
	logic [7:0]        error_position;

	modport source(output valid, output year_value, output month_value, output day_value,
		output hour_value, output minute_value, output second_value, output fraction_value,
		output offset_hours, output offset_minutes, output parse_status,
		output error_position, input ready);
	modport sink(input valid, input year_value, input month_value, input day_value,
		input hour_value, input minute_value, input second_value, input fraction_value,
		input offset_hours, input offset_minutes, input parse_status,
		input error_position, output ready);
endinterface

// ===== src/timestamp_text_parser_unit.sv =====
// Streaming timestamp text parser: one character per transaction, one result per timestamp.
// The unit takes one character of a timestamp text per cycle and folds it into the
// field accumulators in the same cycle, and a new timestamp may start right after the
// last character of the previous one. The character flagged end_of_text produces one
// result transaction, visible on the result channel in the cycle after it is accepted;
// no other character produces a result. Input is held off only while a finished result
// waits in the output register and the result sink is not ready. Texts longer than
// MAX_LENGTH characters are reported as a bad character at position MAX_LENGTH - 1.
module timestamp_text_parser_unit #(
	parameter int unsigned MAX_LENGTH = tstp_pkg::MAX_LENGTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tstp_text_if.sink     text,
	tstp_result_if.source result
);

	localparam int unsigned PW = $clog2(MAX_LENGTH + 1);
	localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_LENGTH);
	localparam logic [7:0] LAST_POS = 8'((MAX_LENGTH - 1) % 256);

	tstp_pkg::phase_t  phase_q, phase_n;
	logic              has_digit_q, has_digit_n;
	logic [15:0]       year_q, year_n;
	logic [3:0]        month_q, month_n;
	logic [4:0]        day_q, day_n;
	logic [4:0]        hour_q, hour_n;
	logic [5:0]        minute_q, minute_n;
	logic [5:0]        second_q, second_n;
	logic [31:0]       fraction_q, fraction_n;
	logic              neg_q, neg_n;
	logic [2:0]        ocount_q, ocount_n;
	logic [6:0]        ohour_q, ohour_n;
	logic [6:0]        ominute_q, ominute_n;
	logic [PW-1:0]     pos_q, pos_n;
	tstp_pkg::status_t err_status_q, err_status_n;
	logic [7:0]        err_index_q, err_index_n;
	logic [7:0]        ostart_q, ostart_n;
	logic [5:0]        omask_q, omask_n;

	logic              res_valid_q;
	logic [15:0]       res_year_q;
	logic [3:0]        res_month_q;
	logic [4:0]        res_day_q;
	logic [4:0]        res_hour_q;
	logic [5:0]        res_minute_q;
	logic [5:0]        res_second_q;
	logic [31:0]       res_fraction_q;
	logic [7:0]        res_ohour_q;
	logic [7:0]        res_ominute_q;
	logic [1:0]        res_status_q;
	logic [7:0]        res_pos_q;

	logic [15:0]       out_year;
	logic [3:0]        out_month;
	logic [4:0]        out_day;
	logic [4:0]        out_hour;
	logic [5:0]        out_minute;
	logic [5:0]        out_second;
	logic [31:0]       out_fraction;
	logic [7:0]        out_ohour;
	logic [7:0]        out_ominute;
	logic [1:0]        out_status;
	logic [7:0]        out_pos;

	logic accept;
	logic emit;

	assign text.ready = !res_valid_q || result.ready;
	assign accept = text.valid && text.ready;
	assign emit = accept && text.end_of_text;

	always_comb begin
		logic [7:0]      c;
		logic            last;
		logic            is_digit;
		logic [3:0]      dig;
		logic            ok;
		logic [PW+7:0]   pos_ext;
		logic [7:0]      p8;
		logic [7:0]      month_cand;
		logic [8:0]      day_cand;
		logic [9:0]      time_cand;
		logic [2:0]      k;
		logic [4:0]      bad;
		logic [2:0]      first_bad;
		logic [7:0]      oh_ext;
		logic [7:0]      om_ext;

		c = text.text_byte;
		last = text.end_of_text;
		is_digit = (c >= tstp_pkg::CH_ZERO) && (c <= tstp_pkg::CH_NINE);
		dig = is_digit ? 4'(c - tstp_pkg::CH_ZERO) : 4'd0;
		pos_ext = {8'd0, pos_q};
		p8 = pos_ext[7:0];
		ok = 1'b1;
		month_cand = '0;
		day_cand = '0;
		time_cand = '0;
		k = '0;
		bad = '0;
		first_bad = '0;

		phase_n = phase_q;
		has_digit_n = has_digit_q;
		year_n = year_q;
		month_n = month_q;
		day_n = day_q;
		hour_n = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		fraction_n = fraction_q;
		neg_n = neg_q;
		ocount_n = ocount_q;
		ohour_n = ohour_q;
		ominute_n = ominute_q;
		err_status_n = err_status_q;
		err_index_n = err_index_q;
		ostart_n = ostart_q;
		omask_n = omask_q;
		pos_n = (pos_q != POS_LIMIT) ? PW'(pos_q + PW'(1)) : pos_q;

		if (phase_q != tstp_pkg::PH_FAILED && pos_q == POS_LIMIT) begin
			phase_n = tstp_pkg::PH_FAILED;
			err_status_n = tstp_pkg::ST_BADCHAR;
			err_index_n = LAST_POS;
		end else begin
			unique case (phase_q)
				tstp_pkg::PH_YEAR: begin
					if (is_digit) begin
						year_n = 16'(year_q * 16'd10 + {12'd0, dig});
					end else if (c == tstp_pkg::CH_MINUS) begin
						phase_n = tstp_pkg::PH_MONTH;
					end else begin
						ok = 1'b0;
					end
				end
				tstp_pkg::PH_MONTH: begin
					if (is_digit) begin
						month_cand = 8'({4'd0, month_q} * 8'd10 + {4'd0, dig});
						month_n = month_cand[3:0];
						ok = (month_cand <= tstp_pkg::MONTH_MAX);
					end else if (c == tstp_pkg::CH_MINUS && month_q != 4'd0) begin
						phase_n = tstp_pkg::PH_DAY;
					end else begin
						ok = 1'b0;
					end
				end
				tstp_pkg::PH_DAY: begin
					if (is_digit) begin
						day_cand = 9'({4'd0, day_q} * 9'd10 + {5'd0, dig});
						day_n = day_cand[4:0];
						ok = (day_cand <= {4'd0, tstp_pkg::day_limit(month_q, year_q[1:0])});
					end else if (c == tstp_pkg::CH_T && day_q != 5'd0) begin
						phase_n = tstp_pkg::PH_HOUR;
						has_digit_n = 1'b0;
					end else begin
						ok = 1'b0;
					end
				end
				tstp_pkg::PH_HOUR: begin
					if (is_digit) begin
						time_cand = tstp_pkg::step10({5'd0, hour_q}, has_digit_q, dig);
						hour_n = time_cand[4:0];
						has_digit_n = 1'b1;
						ok = (time_cand <= tstp_pkg::HOUR_MAX);
					end else if (c == tstp_pkg::CH_COLON && has_digit_q) begin
						phase_n = tstp_pkg::PH_MINUTE;
						has_digit_n = 1'b0;
					end else begin
						ok = 1'b0;
					end
				end
				tstp_pkg::PH_MINUTE: begin
					if (is_digit) begin
						time_cand = tstp_pkg::step10({4'd0, minute_q}, has_digit_q, dig);
						minute_n = time_cand[5:0];
						has_digit_n = 1'b1;
						ok = (time_cand <= tstp_pkg::MIN_SEC_MAX);
					end else if (c == tstp_pkg::CH_COLON && has_digit_q) begin
						phase_n = tstp_pkg::PH_SECOND;
						has_digit_n = 1'b0;
					end else begin
						ok = 1'b0;
					end
				end
				tstp_pkg::PH_SECOND: begin
					if (is_digit) begin
						time_cand = tstp_pkg::step10({4'd0, second_q}, has_digit_q, dig);
						second_n = time_cand[5:0];
						has_digit_n = 1'b1;
						ok = (time_cand <= tstp_pkg::MIN_SEC_MAX);
					end else if (c == tstp_pkg::CH_DOT && has_digit_q) begin
						phase_n = tstp_pkg::PH_FRACTION;
						has_digit_n = 1'b0;
					end else begin
						ok = 1'b0;
					end
				end
				tstp_pkg::PH_FRACTION: begin
					if (is_digit) begin
						fraction_n = has_digit_q ?
							32'(fraction_q * 32'd10 + {28'd0, dig}) : {28'd0, dig};
						has_digit_n = 1'b1;
						ok = !last;
					end else if (!has_digit_q) begin
						ok = 1'b0;
					end else if (c == tstp_pkg::CH_Z) begin
						ok = last;
					end else if (c == tstp_pkg::CH_PLUS || c == tstp_pkg::CH_MINUS) begin
						neg_n = (c == tstp_pkg::CH_MINUS);
						phase_n = tstp_pkg::PH_OFFSET;
						ostart_n = p8 + 8'd1;
						ok = !last;
					end else begin
						ok = 1'b0;
					end
				end
				tstp_pkg::PH_OFFSET: begin
					if (ocount_q < tstp_pkg::OFS_COUNT_MAX) begin
						ocount_n = ocount_q + 3'd1;
					end
					k = ocount_n - 3'd1;
					if (k < tstp_pkg::OFS_LONG_LEN) begin
						if (!is_digit) begin
							omask_n[k] = 1'b1;
						end
						if (k == tstp_pkg::OFS_SEP_IDX && c == tstp_pkg::CH_COLON) begin
							omask_n[tstp_pkg::OFS_COLON_BIT] = 1'b1;
						end
						if (is_digit && k < tstp_pkg::OFS_SEP_IDX) begin
							ohour_n = 7'(ohour_q * 7'd10 + {3'd0, dig});
						end else if (is_digit) begin
							ominute_n = 7'(ominute_q * 7'd10 + {3'd0, dig});
						end
					end
				end
				tstp_pkg::PH_FAILED: begin
				end
				default: begin
				end
			endcase
		end

		if (!ok) begin
			phase_n = tstp_pkg::PH_FAILED;
			err_status_n = tstp_pkg::ST_BADCHAR;
			err_index_n = p8;
		end

		if (last) begin
			unique case (phase_n)
				tstp_pkg::PH_YEAR, tstp_pkg::PH_MONTH, tstp_pkg::PH_DAY,
				tstp_pkg::PH_HOUR, tstp_pkg::PH_MINUTE, tstp_pkg::PH_SECOND: begin
					phase_n = tstp_pkg::PH_FAILED;
					err_status_n = tstp_pkg::ST_EARLY;
					err_index_n = 8'd0;
				end
				tstp_pkg::PH_OFFSET: begin
					if (ocount_n != tstp_pkg::OFS_SHORT_LEN &&
						ocount_n != tstp_pkg::OFS_LONG_LEN) begin
						phase_n = tstp_pkg::PH_FAILED;
						err_status_n = tstp_pkg::ST_BADCHAR;
						err_index_n = p8;
					end else begin
						bad = omask_n[4:0];
						if (ocount_n == tstp_pkg::OFS_LONG_LEN) begin
							bad[tstp_pkg::OFS_SEP_IDX] = !omask_n[tstp_pkg::OFS_SEP_IDX] ||
								!omask_n[tstp_pkg::OFS_COLON_BIT];
						end else begin
							bad[4] = 1'b0;
						end
						for (int i = 4; i >= 0; i--) begin
							if (bad[i]) begin
								first_bad = 3'(i);
							end
						end
						if (|bad) begin
							phase_n = tstp_pkg::PH_FAILED;
							err_status_n = tstp_pkg::ST_BADCHAR;
							err_index_n = ostart_n + {5'd0, first_bad};
						end
					end
				end
				default: begin
				end
			endcase
		end

		oh_ext = {1'b0, ohour_n};
		om_ext = {1'b0, ominute_n};
		if (phase_n == tstp_pkg::PH_FAILED) begin
			out_year = '0;
			out_month = '0;
			out_day = '0;
			out_hour = '0;
			out_minute = '0;
			out_second = '0;
			out_fraction = '0;
			out_ohour = '0;
			out_ominute = '0;
			out_status = err_status_n;
			out_pos = (err_status_n == tstp_pkg::ST_BADCHAR) ? err_index_n : 8'd0;
		end else begin
			out_year = year_n;
			out_month = month_n;
			out_day = day_n;
			out_hour = hour_n;
			out_minute = minute_n;
			out_second = second_n;
			out_fraction = fraction_n;
			out_ohour = neg_n ? 8'(8'd0 - oh_ext) : oh_ext;
			out_ominute = neg_n ? 8'(8'd0 - om_ext) : om_ext;
			out_status = tstp_pkg::ST_VALID;
			out_pos = 8'd0;
		end

		// The last character of a timestamp leaves the parser clean for the next one.
		if (last) begin
			phase_n = tstp_pkg::PH_YEAR;
			has_digit_n = 1'b0;
			year_n = '0;
			month_n = '0;
			day_n = '0;
			hour_n = '0;
			minute_n = '0;
			second_n = '0;
			fraction_n = '0;
			neg_n = 1'b0;
			ocount_n = '0;
			ohour_n = '0;
			ominute_n = '0;
			pos_n = '0;
			err_status_n = tstp_pkg::ST_VALID;
			err_index_n = '0;
			ostart_n = '0;
			omask_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tstp_pkg::PH_YEAR;
			has_digit_q <= 1'b0;
			year_q <= '0;
			month_q <= '0;
			day_q <= '0;
			hour_q <= '0;
			minute_q <= '0;
			second_q <= '0;
			fraction_q <= '0;
			neg_q <= 1'b0;
			ocount_q <= '0;
			ohour_q <= '0;
			ominute_q <= '0;
			pos_q <= '0;
			err_status_q <= tstp_pkg::ST_VALID;
			err_index_q <= '0;
			ostart_q <= '0;
			omask_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			has_digit_q <= has_digit_n;
			year_q <= year_n;
			month_q <= month_n;
			day_q <= day_n;
			hour_q <= hour_n;
			minute_q <= minute_n;
			second_q <= second_n;
			fraction_q <= fraction_n;
			neg_q <= neg_n;
			ocount_q <= ocount_n;
			ohour_q <= ohour_n;
			ominute_q <= ominute_n;
			pos_q <= pos_n;
			err_status_q <= err_status_n;
			err_index_q <= err_index_n;
			ostart_q <= ostart_n;
			omask_q <= omask_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_year_q <= out_year;
			res_month_q <= out_month;
			res_day_q <= out_day;
			res_hour_q <= out_hour;
			res_minute_q <= out_minute;
			res_second_q <= out_second;
			res_fraction_q <= out_fraction;
			res_ohour_q <= out_ohour;
			res_ominute_q <= out_ominute;
			res_status_q <= out_status;
			res_pos_q <= out_pos;
		end
	end

	assign result.valid = res_valid_q;
	assign result.year_value = res_year_q;
	assign result.month_value = res_month_q;
	assign result.day_value = res_day_q;
	assign result.hour_value = res_hour_q;
	assign result.minute_value = res_minute_q;
	assign result.second_value = res_second_q;
	assign result.fraction_value = res_fraction_q;
	assign result.offset_hours = res_ohour_q;
	assign result.offset_minutes = res_ominute_q;
	assign result.parse_status = res_status_q;
	assign result.error_position = res_pos_q;

	// The last character of a timestamp always yields a result transaction next cycle.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.ready && text.end_of_text |=> result.valid)
		else $error("no result after the last character of a timestamp");

	// A failed parse reports no field values.
	a_error_clears_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.parse_status != tstp_pkg::ST_VALID |->
		result.year_value == 16'd0 && result.month_value == 4'd0 &&
		result.day_value == 5'd0 && result.fraction_value == 32'd0 &&
		result.offset_hours == 8'sd0 && result.offset_minutes == 8'sd0)
		else $error("field values present on a failed parse");

	// Only a bad character carries a position.
	a_position_only_on_badchar: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.parse_status != tstp_pkg::ST_BADCHAR |->
		result.error_position == 8'd0)
		else $error("error position set without a bad character");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the timestamp text parser: directed table, then random texts.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tstp_pkg::*;

	localparam int unsigned TEXT_LIMIT  = MAX_LENGTH_DEF;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned RANDOM_CHARS = 1500;
	localparam int unsigned RANDOM_STAMPS = 20;

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [31:0] fraction;
		logic [7:0]  ofs_h;
		logic [7:0]  ofs_m;
		logic [1:0]  status;
		logic [7:0]  err_pos;
	} stamp_t;

	typedef struct packed {
		bit     typed;
		stamp_t want;
	} plan_t;

	typedef struct {
		string  text;
		bit     typed;
		stamp_t want;
		int     nul_at;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tstp_text_if   text_ch();
	tstp_result_if result_ch();

	timestamp_text_parser_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.result(result_ch)
	);

	// Running state of the parse that the checker keeps for itself.
	phase_t      ph_now;
	bit          seen_digit;
	logic [15:0] year_acc;
	int unsigned month_acc;
	int unsigned day_acc;
	int unsigned hour_acc;
	int unsigned minute_acc;
	int unsigned second_acc;
	logic [31:0] frac_acc;
	bit          ofs_neg;
	int unsigned ofs_count;
	logic [6:0]  ofs_hour_acc;
	logic [6:0]  ofs_min_acc;
	int unsigned char_idx;
	status_t     fail_code;
	logic [7:0]  fail_at;
	int unsigned ofs_first;
	logic [5:0]  ofs_bad;

	stamp_t      expected_stamps[$];
	plan_t       plans[$];
	logic [7:0]  draft[$];
	probe_t      probes[$];

	bit          sender_idles = 1'b1;
	bit          sink_stalls = 1'b1;
	int unsigned stamps_sent;
	int unsigned stamps_done;
	int unsigned chars_taken;
	int unsigned mismatches;
	int unsigned seen_valid;
	int unsigned seen_badchar;
	int unsigned seen_early;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void restart_stamp();
		ph_now = PH_YEAR;
		seen_digit = 1'b0;
		year_acc = '0;
		month_acc = 0;
		day_acc = 0;
		hour_acc = 0;
		minute_acc = 0;
		second_acc = 0;
		frac_acc = '0;
		ofs_neg = 1'b0;
		ofs_count = 0;
		ofs_hour_acc = '0;
		ofs_min_acc = '0;
		char_idx = 0;
		fail_code = ST_VALID;
		fail_at = '0;
		ofs_first = 0;
		ofs_bad = '0;
	endfunction

	function automatic void mark_bad(status_t st, int unsigned at);
		ph_now = PH_FAILED;
		fail_code = st;
		fail_at = at[7:0];
	endfunction

	function automatic bit clock_field(inout int unsigned acc, input int unsigned lim,
		input bit dig, input int unsigned d, input logic [7:0] c, input logic [7:0] sep,
		input phase_t nxt);
		if (dig) begin
			acc = seen_digit ? acc * 10 + d : d;
			seen_digit = 1'b1;
			return acc <= lim;
		end
		if (c != sep || !seen_digit)
			return 1'b0;
		ph_now = nxt;
		seen_digit = 1'b0;
		return 1'b1;
	endfunction

	// Folds one character into the parse; returns 1 when it closes a timestamp.
	function automatic bit parse_char(input logic [7:0] c, input bit last, output stamp_t r);
		int unsigned p;
		int unsigned d;
		int unsigned k;
		int unsigned lim;
		bit dig;
		bit ok;
		bit bad;
		p = char_idx;
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		d = dig ? c - CH_ZERO : 0;
		ok = 1'b1;
		r = '0;
		if (char_idx < TEXT_LIMIT)
			char_idx++;
		if (ph_now != PH_FAILED && p >= TEXT_LIMIT)
			mark_bad(ST_BADCHAR, TEXT_LIMIT - 1);
		case (ph_now)
			PH_YEAR: begin
				if (dig)
					year_acc = 16'(year_acc * 10 + d);
				else if (c == CH_MINUS)
					ph_now = PH_MONTH;
				else
					ok = 1'b0;
			end
			PH_MONTH: begin
				if (dig) begin
					month_acc = month_acc * 10 + d;
					ok = month_acc <= MONTH_MAX;
				end else if (c == CH_MINUS && month_acc != 0) begin
					ph_now = PH_DAY;
				end else begin
					ok = 1'b0;
				end
			end
			PH_DAY: begin
				if (dig) begin
					day_acc = day_acc * 10 + d;
					case (month_acc)
						4, 6, 9, 11: lim = DAY_SHORT;
						2: lim = (year_acc[1:0] == 2'd0) ? DAY_FEB + 1 : DAY_FEB;
						default: lim = DAY_LONG;
					endcase
					ok = day_acc <= lim;
				end else if (c == CH_T && day_acc != 0) begin
					ph_now = PH_HOUR;
					seen_digit = 1'b0;
				end else begin
					ok = 1'b0;
				end
			end
			PH_HOUR: ok = clock_field(hour_acc, HOUR_MAX, dig, d, c, CH_COLON, PH_MINUTE);
			PH_MINUTE: ok = clock_field(minute_acc, MIN_SEC_MAX, dig, d, c, CH_COLON, PH_SECOND);
			PH_SECOND: ok = clock_field(second_acc, MIN_SEC_MAX, dig, d, c, CH_DOT, PH_FRACTION);
			PH_FRACTION: begin
				if (dig) begin
					frac_acc = seen_digit ? 32'(frac_acc * 10 + d) : 32'(d);
					seen_digit = 1'b1;
					if (last)
						ok = 1'b0;
				end else if (!seen_digit) begin
					ok = 1'b0;
				end else if (c == CH_Z) begin
					ok = last;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					ofs_neg = (c == CH_MINUS);
					ph_now = PH_OFFSET;
					ofs_first = p + 1;
					if (last)
						ok = 1'b0;
				end else begin
					ok = 1'b0;
				end
			end
			PH_OFFSET: begin
				if (ofs_count < OFS_COUNT_MAX)
					ofs_count++;
				k = ofs_count - 1;
				if (k < OFS_LONG_LEN) begin
					if (!dig)
						ofs_bad[k] = 1'b1;
					if (k == OFS_SEP_IDX && c == CH_COLON)
						ofs_bad[OFS_COLON_BIT] = 1'b1;
					if (dig && k < OFS_SEP_IDX)
						ofs_hour_acc = 7'(ofs_hour_acc * 10 + d);
					else if (dig)
						ofs_min_acc = 7'(ofs_min_acc * 10 + d);
				end
			end
			default: ;
		endcase
		if (!ok)
			mark_bad(ST_BADCHAR, p);
		if (!last)
			return 1'b0;
		case (ph_now)
			PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND: mark_bad(ST_EARLY, 0);
			PH_OFFSET: begin
				if (ofs_count != OFS_SHORT_LEN && ofs_count != OFS_LONG_LEN) begin
					mark_bad(ST_BADCHAR, p);
				end else begin
					for (k = 0; k < ofs_count; k++) begin
						bad = ofs_bad[k];
						if (k == OFS_SEP_IDX && ofs_count == OFS_LONG_LEN)
							bad = !bad || !ofs_bad[OFS_COLON_BIT];
						if (bad) begin
							mark_bad(ST_BADCHAR, ofs_first + k);
							break;
						end
					end
				end
			end
			default: ;
		endcase
		if (ph_now == PH_FAILED) begin
			r.status = fail_code;
			r.err_pos = (fail_code == ST_BADCHAR) ? fail_at : 8'd0;
		end else begin
			r.year = year_acc;
			r.month = 4'(month_acc);
			r.day = 5'(day_acc);
			r.hour = 5'(hour_acc);
			r.minute = 6'(minute_acc);
			r.second = 6'(second_acc);
			r.fraction = frac_acc;
			r.ofs_h = ofs_neg ? 8'(0 - {1'b0, ofs_hour_acc}) : {1'b0, ofs_hour_acc};
			r.ofs_m = ofs_neg ? 8'(0 - {1'b0, ofs_min_acc}) : {1'b0, ofs_min_acc};
			r.status = ST_VALID;
		end
		restart_stamp();
		return 1'b1;
	endfunction

	function automatic stamp_t rejected(status_t st, logic [7:0] at);
		stamp_t r;
		r = '0;
		r.status = st;
		r.err_pos = at;
		return r;
	endfunction

	function automatic probe_t probe(string t, bit typed = 1'b0, stamp_t want = '0,
		int nul_at = -1);
		probe_t pr;
		pr.text = t;
		pr.typed = typed;
		pr.want = want;
		pr.nul_at = nul_at;
		return pr;
	endfunction

	// Decimal field text, biased toward its limit, just past it, zero and empty.
	function automatic string num_field(int unsigned hi);
		int unsigned r;
		int unsigned v;
		string s;
		r = $urandom_range(0, 99);
		if (r < 4)
			return "";
		if (r < 30)
			v = hi;
		else if (r < 40)
			v = hi + 1 + $urandom_range(0, 20);
		else if (r < 45)
			v = 0;
		else
			v = $urandom_range(0, hi);
		s = $sformatf("%0d", v);
		if (s.len() < 2 && r % 4 != 0)
			s = {"0", s};
		if (r % 11 == 0)
			s = {"0", s};
		return s;
	endfunction

	function automatic string digit_run(int unsigned n);
		string s;
		s = "";
		for (int unsigned i = 0; i < n; i++)
			s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		return s;
	endfunction

	// Builds one random text in draft: mostly well formed, the rest cut, corrupted, noise or overlong.
	task automatic build_random_text();
		string yr_s;
		string mon_s;
		string w;
		string zone;
		string pool;
		int unsigned kind;
		int unsigned r;
		int unsigned lim;
		int unsigned n;
		int m;
		pool = "0123456789:Z+";
		kind = $urandom_range(0, 99);
		r = $urandom_range(0, 99);
		if (kind >= 98)
			yr_s = digit_run($urandom_range(240, 300));
		else if (r < 5)
			yr_s = "";
		else if (r < 12)
			yr_s = $sformatf("%0d", $urandom_range(10000, 999999));
		else if (r < 16)
			yr_s = $sformatf("6553%0d", $urandom_range(0, 9));
		else
			yr_s = $sformatf("%04d", $urandom_range(0, 9999));
		mon_s = num_field(MONTH_MAX);
		m = mon_s.atoi();
		if (m == 4 || m == 6 || m == 9 || m == 11)
			lim = DAY_SHORT;
		else if (m == 2)
			lim = (yr_s.atoi() % 4 == 0) ? DAY_FEB + 1 : DAY_FEB;
		else
			lim = DAY_LONG;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			zone = "Z";
		end else if (r < 85) begin
			zone = {($urandom_range(0, 1) != 0) ? "+" : "-", $sformatf("%02d", $urandom_range(0, 99))};
			if ($urandom_range(0, 1) != 0)
				zone = {zone, ":"};
			zone = {zone, $sformatf("%02d", $urandom_range(0, 99))};
		end else begin
			zone = ($urandom_range(0, 1) != 0) ? "+" : "-";
			n = $urandom_range(0, 7);
			for (int unsigned i = 0; i < n; i++) begin
				m = $urandom_range(0, pool.len() - 1);
				zone = {zone, pool.substr(m, m)};
			end
		end
		r = $urandom_range(0, 99);
		n = (r < 4) ? 0 : (r < 20) ? $urandom_range(10, 14) : $urandom_range(1, 9);
		w = {yr_s, "-", mon_s, "-", num_field(lim), "T", num_field(HOUR_MAX), ":",
			num_field(MIN_SEC_MAX), ":", num_field(MIN_SEC_MAX), ".", digit_run(n), zone};
		draft.delete();
		for (int i = 0; i < w.len(); i++)
			draft.push_back(w[i]);
		if (kind >= 62 && kind < 74) begin
			n = $urandom_range(1, draft.size());
			while (draft.size() > n)
				void'(draft.pop_back());
		end else if (kind >= 74 && kind < 86) begin
			n = $urandom_range(1, 3);
			for (int unsigned i = 0; i < n; i++)
				draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (kind >= 86 && kind < 98) begin
			draft.delete();
			n = $urandom_range(1, 24);
			for (int unsigned i = 0; i < n; i++)
				draft.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic put_char(input logic [7:0] c, input bit last);
		int unsigned r;
		int unsigned gap;
		r = $urandom_range(0, 99);
		gap = 0;
		if (sender_idles && r >= 65)
			gap = (r < 93) ? $urandom_range(1, 3) : $urandom_range(4, 30);
		if (gap != 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= c;
		text_ch.end_of_text <= last;
		do @(posedge clk); while (!text_ch.ready);
	endtask

	task automatic send_text(input bit typed, input stamp_t want);
		plan_t pl;
		pl.typed = typed;
		pl.want = want;
		plans.push_back(pl);
		for (int i = 0; i < draft.size(); i++)
			put_char(draft[i], i == draft.size() - 1);
		stamps_sent++;
	endtask

	// Stops sending and waits until every expected result has come back.
	task automatic drain_results();
		if (stamps_done < stamps_sent) begin
			text_ch.valid <= 1'b0;
			wait (stamps_done >= stamps_sent);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : watch
		stamp_t want;
		stamp_t got;
		plan_t pl;
		if (arst_n) begin
			if (text_ch.valid && text_ch.ready) begin
				chars_taken++;
				if (parse_char(text_ch.text_byte, text_ch.end_of_text, want)) begin
					pl = plans.pop_front();
					if (pl.typed)
						want = pl.want;
					expected_stamps.push_back(want);
					case (want.status)
						ST_VALID: seen_valid++;
						ST_BADCHAR: seen_badchar++;
						default: seen_early++;
					endcase
				end
			end
			if (result_ch.valid && result_ch.ready) begin
				stamps_done++;
				got = '{year: result_ch.year_value, month: result_ch.month_value,
					day: result_ch.day_value, hour: result_ch.hour_value,
					minute: result_ch.minute_value, second: result_ch.second_value,
					fraction: result_ch.fraction_value, ofs_h: result_ch.offset_hours,
					ofs_m: result_ch.offset_minutes, status: result_ch.parse_status,
					err_pos: result_ch.error_position};
				if (expected_stamps.size() == 0) begin
					$display("%0t ns: result transaction with nothing expected, actual status %0d",
						$time, got.status);
					mismatches++;
				end else begin
					want = expected_stamps.pop_front();
					check_field("year_value", 32'(want.year), 32'(got.year));
					check_field("month_value", 32'(want.month), 32'(got.month));
					check_field("day_value", 32'(want.day), 32'(got.day));
					check_field("hour_value", 32'(want.hour), 32'(got.hour));
					check_field("minute_value", 32'(want.minute), 32'(got.minute));
					check_field("second_value", 32'(want.second), 32'(got.second));
					check_field("fraction_value", want.fraction, got.fraction);
					check_field("offset_hours", 32'(want.ofs_h), 32'(got.ofs_h));
					check_field("offset_minutes", 32'(want.ofs_m), 32'(got.ofs_m));
					check_field("parse_status", 32'(want.status), 32'(got.status));
					check_field("error_position", 32'(want.err_pos), 32'(got.err_pos));
				end
			end
		end
	end

	initial begin : sink_side
		int unsigned r;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (sink_stalls) begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				r = $urandom_range(0, 99);
				result_ch.ready <= 1'b0;
				repeat ((r < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL timestamp_text_parser_unit");
		$finish;
	end

	initial begin : stimulus
		string long_text;
		int unsigned random_stamps;
		text_ch.valid <= 1'b0;
		text_ch.text_byte <= 8'h00;
		text_ch.end_of_text <= 1'b0;
		restart_stamp();

		long_text = "";
		for (int i = 0; i < 300; i++)
			long_text = {long_text, "7"};
		long_text = {long_text, "-01-01T00:00:00.0Z"};

		probes.push_back(probe("2024-02-29T23:59:60.5Z", 1'b1, '{year: 16'd2024, month: 4'd2,
			day: 5'd29, hour: 5'd23, minute: 6'd59, second: 6'd60, fraction: 32'd5,
			ofs_h: 8'd0, ofs_m: 8'd0, status: ST_VALID, err_pos: 8'd0}));
		probes.push_back(probe("65535-12-31T24:60:60.4294967295Z", 1'b1, '{year: 16'd65535,
			month: 4'd12, day: 5'd31, hour: 5'd24, minute: 6'd60, second: 6'd60,
			fraction: 32'hFFFF_FFFF, ofs_h: 8'd0, ofs_m: 8'd0, status: ST_VALID, err_pos: 8'd0}));
		probes.push_back(probe("65536-1-1T0:0:0.4294967296Z"));
		probes.push_back(probe("-01-01T00:00:00.0Z"));
		probes.push_back(probe("2023-02-29T00:00:00.0Z", 1'b1, rejected(ST_BADCHAR, 8'd9)));
		probes.push_back(probe("2024-13-01T00:00:00.0Z", 1'b1, rejected(ST_BADCHAR, 8'd6)));
		probes.push_back(probe("2024-00-01T00:00:00.0Z", 1'b1, rejected(ST_BADCHAR, 8'd7)));
		probes.push_back(probe("2024--01T00:00:00.0Z", 1'b1, rejected(ST_BADCHAR, 8'd5)));
		probes.push_back(probe("2024-04-31T00:00:00.0Z", 1'b1, rejected(ST_BADCHAR, 8'd9)));
		probes.push_back(probe("2024-01-01T25:00:00.0Z", 1'b1, rejected(ST_BADCHAR, 8'd12)));
		probes.push_back(probe("2024-01-01T:00:00.0Z", 1'b1, rejected(ST_BADCHAR, 8'd11)));
		probes.push_back(probe("2024-01-01T00:61:00.0Z", 1'b1, rejected(ST_BADCHAR, 8'd15)));
		probes.push_back(probe("2024-01-01T00:00:60.Z", 1'b1, rejected(ST_BADCHAR, 8'd20)));
		probes.push_back(probe("2024-01-01T00:00", 1'b1, rejected(ST_EARLY, 8'd0)));
		probes.push_back(probe("2024-01-01T00:00:", 1'b1, rejected(ST_EARLY, 8'd0)));
		probes.push_back(probe("2024-01-01T00:00:00.12", 1'b1, rejected(ST_BADCHAR, 8'd21)));
		probes.push_back(probe("2024-01-01T00:00:00.1Z0", 1'b1, rejected(ST_BADCHAR, 8'd21)));
		probes.push_back(probe("2024-01-01T00:00:00.1+", 1'b1, rejected(ST_BADCHAR, 8'd21)));
		probes.push_back(probe("1999-07-04T12:30:45.678+0530"));
		probes.push_back(probe("1999-07-04T12:30:45.678-09:30"));
		probes.push_back(probe("1999-07-04T12:30:45.678+99:99"));
		probes.push_back(probe("2000-01-01T00:00:00.0+05:3", 1'b1, rejected(ST_BADCHAR, 8'd24)));
		probes.push_back(probe("2000-01-01T00:00:00.0+053", 1'b1, rejected(ST_BADCHAR, 8'd24)));
		probes.push_back(probe("2000-01-01T00:00:00.0+05-30", 1'b1, rejected(ST_BADCHAR, 8'd24)));
		probes.push_back(probe("2000-01-01T00:00:00.0+05:3x", 1'b1, rejected(ST_BADCHAR, 8'd26)));
		probes.push_back(probe(long_text, 1'b1, rejected(ST_BADCHAR, 8'd255)));
		probes.push_back(probe("\377Z", 1'b1, rejected(ST_BADCHAR, 8'd0), 1));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			draft.delete();
			for (int j = 0; j < probes[i].text.len(); j++)
				draft.push_back(probes[i].text[j]);
			if (probes[i].nul_at >= 0)
				draft[probes[i].nul_at] = 8'h00;
			send_text(probes[i].typed, probes[i].want);
		end
		drain_results();

		random_stamps = 0;
		while (chars_taken < RANDOM_CHARS || random_stamps < RANDOM_STAMPS) begin
			if ($urandom_range(0, 15) == 0) begin
				sender_idles = ($urandom_range(0, 3) != 0);
				sink_stalls = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 99) < 6)
				drain_results();
			build_random_text();
			send_text(1'b0, '0);
			random_stamps++;
		end
		text_ch.valid <= 1'b0;

		wait (stamps_done >= stamps_sent);
		repeat (8) @(posedge clk);
		if (expected_stamps.size() != 0) begin
			$display("%0t ns: %0d expected results never arrived", $time, expected_stamps.size());
			mismatches++;
		end
		$display("Parsed %0d characters in %0d timestamps (%0d directed).", chars_taken,
			stamps_sent, probes.size());
		$display("Outcomes: %0d valid, %0d bad character, %0d ended early; %0d mismatches.",
			seen_valid, seen_badchar, seen_early, mismatches);
		if (mismatches == 0)
			$display("PASS timestamp_text_parser_unit");
		else
			$display("FAIL timestamp_text_parser_unit");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/tstp_pkg.sv
src/tstp_if.sv
src/timestamp_text_parser_unit.sv
test/tb.sv
